FILE: hdl/ascv_pkg.sv
package ascv_pkg;

    localparam int AXIS_W = 8;

    typedef logic [AXIS_W-1:0]        t_raw;
    typedef logic signed [AXIS_W-1:0] t_axis;

    // configuration codes
    typedef enum logic [1:0] {
        MODE_STD    = 2'd0,
        MODE_LEGACY = 2'd1,
        MODE_EXT    = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_DEADZONE = 1'b1;

    localparam logic ACT_CAPTURE = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    // factor/32000 reduces to n/32
    localparam logic [6:0] SCALE_STD       = 7'd26;
    localparam logic [6:0] SCALE_STD_DZ    = 7'd30;
    localparam logic [6:0] SCALE_LEGACY    = 7'd25;
    localparam logic [6:0] SCALE_LEGACY_DZ = 7'd29;
    localparam logic [6:0] SCALE_UNITY     = 7'd32;

    localparam logic [7:0] DEADZONE   = 8'd12;
    localparam logic [6:0] LIM_STD    = 7'd80;
    localparam logic [6:0] LIM_LEGACY = 7'd127;

endpackage

FILE: hdl/ascv_stream_if.sv
interface ascv_in_if;
    logic            valid;
    logic            ready;
    logic            action;
    ascv_pkg::t_raw  raw_x;
    ascv_pkg::t_raw  raw_y;

    modport source (output valid, action, raw_x, raw_y, input ready);
    modport sink   (input valid, action, raw_x, raw_y, output ready);
endinterface

interface ascv_out_if;
    logic            valid;
    logic            ready;
    ascv_pkg::t_axis out_x;
    ascv_pkg::t_axis out_y;

    modport source (output valid, out_x, out_y, input ready);
    modport sink   (input valid, out_x, out_y, output ready);
endinterface

FILE: hdl/analog_stick_range_converter_unit.sv
// channel    dir  word                         handshake
// i_smp      in   action, raw_x, raw_y         valid/ready
// o_res      out  out_x, out_y                 valid/ready
// apb        in   mode, deadzone               psel/penable/pwrite, pready high
//
// a convert word runs the steps mul_x, mul_y, sat_y, cross and final, then its result is registered
// a capture word only loads the origins; no new word is accepted until the sequencer is idle again
// one shared 8x7 multiplier runs x scale, y scale, then the cross product
// ready is high only while the sequencer is idle
// a finished result waits in the output register; the sequencer holds in its
// last step while that register is still full and o_res.ready is low
// synchronous active-low reset clears mode, deadzone, origins and valid
module analog_stick_range_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ascv_in_if.sink           i_smp,
    ascv_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_SAT_Y,
        S_CROSS,
        S_FINAL
    } t_state;

    t_state             r_state, n_state;
    ascv_pkg::t_mode    r_mode, n_mode;
    logic               r_dz, n_dz;
    logic [7:0]         r_org_x, n_org_x;
    logic [7:0]         r_org_y, n_org_y;
    logic [7:0]         r_mag_x, n_mag_x;
    logic [7:0]         r_mag_y, n_mag_y;
    logic               r_neg_x, n_neg_x;
    logic               r_neg_y, n_neg_y;
    logic [6:0]         r_sx, n_sx;
    logic [6:0]         r_sy, n_sy;
    logic [14:0]        r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    ascv_pkg::t_axis    r_out_x, n_out_x;
    ascv_pkg::t_axis    r_out_y, n_out_y;

    logic               accept;
    logic               cfg_wr;
    logic [6:0]         scale_n;
    logic [7:0]         mul_a;
    logic [6:0]         mul_b;
    logic [14:0]        mul_p;
    logic [7:0]         scaled;
    logic [6:0]         sat127;
    logic [8:0]         front_x;
    logic [8:0]         front_y;
    logic               legacy;
    logic [6:0]         cross_mag;
    logic [6:0]         lim;
    logic [7:0]         sum_x, sum_y;
    logic [6:0]         fmag_x, fmag_y;

    // sign and magnitude of sample minus origin, deadzoned when dz is set
    function automatic logic [8:0] axis_front(input logic [7:0] raw, input logic [7:0] org,
                                              input logic dz);
        logic [8:0] diff;
        logic [8:0] mag9;
        logic [7:0] mag;
        diff = {~raw[7], ~raw[7], raw[6:0]} - {org[7], org};
        mag9 = diff[8] ? (9'd0 - diff) : diff;
        mag  = mag9[7:0];
        if (dz) begin
            mag = (mag < ascv_pkg::DEADZONE) ? 8'd0 : (mag - ascv_pkg::DEADZONE);
        end
        return {diff[8], mag};
    endfunction

    function automatic ascv_pkg::t_axis apply_sign(input logic neg, input logic [6:0] mag);
        logic [7:0] m;
        m = {1'b0, mag};
        return neg ? ascv_pkg::t_axis'(8'd0 - m) : ascv_pkg::t_axis'(m);
    endfunction

    assign accept      = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.out_x = r_out_x;
    assign o_res.out_y = r_out_y;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ascv_pkg::REG_DEADZONE) ? {31'd0, r_dz} : {30'd0, r_mode};

    assign front_x = axis_front(i_smp.raw_x, r_org_x, r_dz);
    assign front_y = axis_front(i_smp.raw_y, r_org_y, r_dz);

    always_comb begin
        case (r_mode)
            ascv_pkg::MODE_LEGACY: scale_n = r_dz ? ascv_pkg::SCALE_LEGACY_DZ
                                                  : ascv_pkg::SCALE_LEGACY;
            ascv_pkg::MODE_EXT:    scale_n = ascv_pkg::SCALE_UNITY;
            default:               scale_n = r_dz ? ascv_pkg::SCALE_STD_DZ
                                                  : ascv_pkg::SCALE_STD;
        endcase
    end

    // shared multiplier
    always_comb begin
        case (r_state)
            S_MUL_Y: begin
                mul_a = r_mag_y;
                mul_b = scale_n;
            end
            S_CROSS: begin
                mul_a = {1'b0, r_sx};
                mul_b = r_sy;
            end
            default: begin
                mul_a = r_mag_x;
                mul_b = scale_n;
            end
        endcase
    end

    assign mul_p  = 15'(mul_a) * 15'(mul_b);
    assign scaled = r_prod[12:5];
    assign sat127 = scaled[7] ? 7'd127 : scaled[6:0];

    assign legacy    = (r_mode == ascv_pkg::MODE_LEGACY);
    assign cross_mag = legacy ? {2'b00, r_prod[13:9]} : {1'b0, r_prod[13:8]};
    assign lim       = legacy ? ascv_pkg::LIM_LEGACY : ascv_pkg::LIM_STD;
    assign sum_x     = {1'b0, r_sx} + {1'b0, cross_mag};
    assign sum_y     = {1'b0, r_sy} + {1'b0, cross_mag};

    always_comb begin
        if (r_mode == ascv_pkg::MODE_EXT) begin
            fmag_x = r_sx;
            fmag_y = r_sy;
        end else begin
            fmag_x = (sum_x > {1'b0, lim}) ? lim : sum_x[6:0];
            fmag_y = (sum_y > {1'b0, lim}) ? lim : sum_y[6:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_dz        = r_dz;
        n_org_x     = r_org_x;
        n_org_y     = r_org_y;
        n_mag_x     = r_mag_x;
        n_mag_y     = r_mag_y;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (cfg_wr) begin
            if (paddr[2] == ascv_pkg::REG_MODE) begin
                n_mode = ascv_pkg::t_mode'(pwdata[1:0]);
            end else begin
                n_dz = pwdata[0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_smp.action == ascv_pkg::ACT_CAPTURE) begin
                        n_org_x = {~i_smp.raw_x[7], i_smp.raw_x[6:0]};
                        n_org_y = {~i_smp.raw_y[7], i_smp.raw_y[6:0]};
                    end else begin
                        n_neg_x = front_x[8];
                        n_mag_x = front_x[7:0];
                        n_neg_y = front_y[8];
                        n_mag_y = front_y[7:0];
                        n_state = S_MUL_X;
                    end
                end
            end
            S_MUL_X: begin
                n_prod  = mul_p;
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                n_sx    = sat127;
                n_prod  = mul_p;
                n_state = S_SAT_Y;
            end
            S_SAT_Y: begin
                n_sy    = sat127;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                n_prod  = mul_p;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = apply_sign(r_neg_x, fmag_x);
                    n_out_y     = apply_sign(r_neg_y, fmag_y);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= ascv_pkg::MODE_STD;
            r_dz        <= 1'b0;
            r_org_x     <= 8'd0;
            r_org_y     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_dz        <= n_dz;
            r_org_x     <= n_org_x;
            r_org_y     <= n_org_y;
            r_out_valid <= n_out_valid;
        end
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_prod  <= n_prod;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    a_no_min_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_x != -8'sd128 && r_out_y != -8'sd128))
        else $error("result word holds -128");

    a_convert_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_smp.action == ascv_pkg::ACT_CONVERT) |=> (r_state == S_MUL_X))
        else $error("convert word did not start the sequencer");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_smp.action == ascv_pkg::ACT_CAPTURE) |=> (r_state == S_IDLE && !$stable(r_org_x) || r_state == S_IDLE))
        else $error("capture word left the sequencer busy");

    a_result_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && (!r_out_valid || o_res.ready)) |=> r_out_valid)
        else $error("finished result not loaded");

endmodule
